### design/rv32id_pkg.sv
// Package for the RV32 instruction decoder: class and format codes,
// major opcodes and funct fields. No dependencies.

package rv32id_pkg;

	typedef enum logic [3:0] {
		CLS_LW    = 4'd0,
		CLS_SW    = 4'd1,
		CLS_ADDI  = 4'd2,
		CLS_SLTI  = 4'd3,
		CLS_SLTIU = 4'd4,
		CLS_JALR  = 4'd5,
		CLS_ADD   = 4'd6,
		CLS_SUB   = 4'd7,
		CLS_BEQ   = 4'd8,
		CLS_BNE   = 4'd9,
		CLS_LUI   = 4'd10,
		CLS_AUIPC = 4'd11,
		CLS_JAL   = 4'd12,
		CLS_TRAP  = 4'd13,
		CLS_INV   = 4'd14
	} op_class_t;

	typedef enum logic [2:0] {
		FMT_R    = 3'd0,
		FMT_I    = 3'd1,
		FMT_S    = 3'd2,
		FMT_B    = 3'd3,
		FMT_U    = 3'd4,
		FMT_J    = 3'd5,
		FMT_NONE = 3'd6
	} format_t;

	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_TRAP   = 7'h6B;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

endpackage

### design/rv32_instruction_decoder.sv
// RV32 instruction decoder top level: input register, decode logic, result register.
// Depends on rv32id_pkg.

// One instruction word is taken as a beat on every cycle that start is high; busy
// never rises. Each beat gives exactly one result, shown with done high for one
// cycle once the beat has passed the input register and then the result register,
// in the order the beats came. Words outside the supported subset, including known
// opcodes with other funct3 or funct7 values, decode as invalid with format none
// and all other fields zero. The receiver cannot stall.
module rv32_instruction_decoder
	import rv32id_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [31:0] instr_word,
	output logic               done,
	output logic        [3:0]  op_class,
	output logic        [2:0]  format,
	output logic        [4:0]  src1_index,
	output logic        [4:0]  src2_index,
	output logic        [4:0]  dest_index,
	output logic               dest_discard,
	output logic signed [31:0] immediate
);

	logic        valid_s1;
	logic [31:0] instr_s1;

	op_class_t   cls;
	format_t     fmt;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [4:0]  rd;
	logic        disc;
	logic [31:0] imm;

	logic        done_s2;
	op_class_t   cls_s2;
	format_t     fmt_s2;
	logic [4:0]  rs1_s2;
	logic [4:0]  rs2_s2;
	logic [4:0]  rd_s2;
	logic        disc_s2;
	logic [31:0] imm_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			instr_s1 <= instr_word;
		end
	end

	assign opc = instr_s1[6:0];
	assign f3  = instr_s1[14:12];
	assign f7  = instr_s1[31:25];

	always_comb begin
		cls = CLS_INV;
		fmt = FMT_NONE;
		unique case (opc)
			OPC_LOAD: begin
				if (f3 == F3_WORD) begin
					cls = CLS_LW;
					fmt = FMT_I;
				end
			end
			OPC_STORE: begin
				if (f3 == F3_WORD) begin
					cls = CLS_SW;
					fmt = FMT_S;
				end
			end
			OPC_OP_IMM: begin
				if (f3 == F3_ADD) begin
					cls = CLS_ADDI;
					fmt = FMT_I;
				end else if (f3 == F3_WORD) begin
					cls = CLS_SLTI;
					fmt = FMT_I;
				end else if (f3 == F3_SLTU) begin
					cls = CLS_SLTIU;
					fmt = FMT_I;
				end
			end
			OPC_LUI: begin
				cls = CLS_LUI;
				fmt = FMT_U;
			end
			OPC_AUIPC: begin
				cls = CLS_AUIPC;
				fmt = FMT_U;
			end
			OPC_OP: begin
				if (f3 == F3_ADD && f7 == F7_BASE) begin
					cls = CLS_ADD;
					fmt = FMT_R;
				end else if (f3 == F3_ADD && f7 == F7_ALT) begin
					cls = CLS_SUB;
					fmt = FMT_R;
				end
			end
			OPC_BRANCH: begin
				if (f3 == F3_ADD) begin
					cls = CLS_BEQ;
					fmt = FMT_B;
				end else if (f3 == F3_BNE) begin
					cls = CLS_BNE;
					fmt = FMT_B;
				end
			end
			OPC_JAL: begin
				cls = CLS_JAL;
				fmt = FMT_J;
			end
			OPC_JALR: begin
				if (f3 == F3_ADD) begin
					cls = CLS_JALR;
					fmt = FMT_I;
				end
			end
			OPC_TRAP: begin
				cls = CLS_TRAP;
				fmt = FMT_NONE;
			end
			default: begin
				cls = CLS_INV;
				fmt = FMT_NONE;
			end
		endcase
	end

	always_comb begin
		rs1  = 5'd0;
		rs2  = 5'd0;
		rd   = 5'd0;
		disc = 1'b0;
		imm  = 32'd0;
		if (fmt == FMT_R || fmt == FMT_I || fmt == FMT_S || fmt == FMT_B) begin
			rs1 = instr_s1[19:15];
		end
		if (fmt == FMT_R || fmt == FMT_S || fmt == FMT_B) begin
			rs2 = instr_s1[24:20];
		end
		if (fmt == FMT_R || fmt == FMT_I || fmt == FMT_U || fmt == FMT_J) begin
			rd   = instr_s1[11:7];
			disc = (instr_s1[11:7] == 5'd0);
		end
		unique case (fmt)
			FMT_I: imm = {{20{instr_s1[31]}}, instr_s1[31:20]};
			FMT_S: imm = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
			FMT_B: imm = {{20{instr_s1[31]}}, instr_s1[7], instr_s1[30:25],
				instr_s1[11:8], 1'b0};
			FMT_U: imm = {instr_s1[31:12], 12'd0};
			FMT_J: imm = {{12{instr_s1[31]}}, instr_s1[19:12], instr_s1[20],
				instr_s1[30:21], 1'b0};
			default: imm = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cls_s2  <= cls;
			fmt_s2  <= fmt;
			rs1_s2  <= rs1;
			rs2_s2  <= rs2;
			rd_s2   <= rd;
			disc_s2 <= disc;
			imm_s2  <= imm;
		end
	end

	assign done         = done_s2;
	assign op_class     = cls_s2;
	assign format       = fmt_s2;
	assign src1_index   = rs1_s2;
	assign src2_index   = rs2_s2;
	assign dest_index   = rd_s2;
	assign dest_discard = disc_s2;
	assign immediate    = $signed(imm_s2);

endmodule

### design/rv32id_chk.sv
// Port checker for rv32_instruction_decoder, attached by bind.
// Depends on rv32id_pkg.

module rv32id_chk
	import rv32id_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic        [3:0]  op_class,
	input logic        [2:0]  format,
	input logic        [4:0]  src1_index,
	input logic        [4:0]  src2_index,
	input logic        [4:0]  dest_index,
	input logic               dest_discard,
	input logic signed [31:0] immediate
);

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat gave no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without an accepted beat");

	a_none_format_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && format == FMT_NONE) |-> (src1_index == 5'd0 && src2_index == 5'd0 &&
		dest_index == 5'd0 && !dest_discard && immediate == 32'sd0))
		else $error("format none with nonzero fields");

	a_class_format: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (op_class == CLS_INV || op_class == CLS_TRAP)) |-> format == FMT_NONE)
		else $error("invalid or trap class with a real format");

	a_discard_rd0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dest_discard) |-> dest_index == 5'd0)
		else $error("discard flagged for nonzero destination");

endmodule

bind rv32_instruction_decoder rv32id_chk u_rv32id_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.op_class     (op_class),
	.format       (format),
	.src1_index   (src1_index),
	.src2_index   (src2_index),
	.dest_index   (dest_index),
	.dest_discard (dest_discard),
	.immediate    (immediate)
);
